### rtl/qcd_pkg.sv
package qcd_pkg;

    localparam int IDX_DEPTH = 64;
    localparam int IDX_AW    = 6;
    localparam int PIX_W     = 32;

    localparam logic [7:0] OP_RGB  = 8'hFE;
    localparam logic [7:0] OP_RGBA = 8'hFF;

    localparam logic [1:0] TAG_INDEX = 2'b00;
    localparam logic [1:0] TAG_DIFF  = 2'b01;
    localparam logic [1:0] TAG_LUMA  = 2'b10;
    localparam logic [1:0] TAG_RUN   = 2'b11;

    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_RGB  = 2'd1;
    localparam logic [1:0] PEND_RGBA = 2'd2;
    localparam logic [1:0] PEND_LUMA = 2'd3;

    localparam logic [7:0] LUMA_BIAS = 8'd32;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_pixel;

    localparam t_pixel PIX_RESET = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};

    typedef struct packed {
        logic [1:0] pend;
        logic [2:0] left;
        t_pixel     partial;
        logic [5:0] luma_diff;
        t_pixel     prev;
    } t_dec_state;

    typedef struct packed {
        t_dec_state       next;
        t_pixel           pixel;
        logic             emit;
        logic             is_run;
        logic [5:0]       run_arg;
        logic             wr_en;
        logic [IDX_AW-1:0] wr_addr;
    } t_dec_out;

    function automatic logic [IDX_AW-1:0] pixel_slot(input t_pixel p);
        logic [IDX_AW-1:0] s;
        s = IDX_AW'(p.r[5:0] * 6'd3) + IDX_AW'(p.g[5:0] * 6'd5)
          + IDX_AW'(p.b[5:0] * 6'd7) + IDX_AW'(p.a[5:0] * 6'd11);
        return s;
    endfunction

endpackage

### rtl/qcd_ram.sv
module qcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/qcd_op_decode.sv
module qcd_op_decode
    import qcd_pkg::*;
(
    input  logic [7:0] i_byte,
    input  t_dec_state i_state,
    input  t_pixel     i_idx_pixel,
    output t_dec_out   o_dec
);

    logic [2:0] total;
    logic [1:0] chan_sel;
    t_pixel     part;
    logic [7:0] vg;
    t_pixel     pix;
    logic       finish;

    always_comb begin
        o_dec          = '0;
        o_dec.next     = i_state;
        o_dec.run_arg  = i_byte[5:0];
        pix            = i_state.prev;
        finish         = 1'b0;
        total          = (i_state.pend == PEND_RGB) ? 3'd3 : 3'd4;
        chan_sel       = 2'(total - i_state.left);
        part           = i_state.partial;
        vg             = 8'({2'b00, i_state.luma_diff}) - LUMA_BIAS;

        unique case (i_state.pend)
            PEND_RGB, PEND_RGBA: begin
                unique case (chan_sel)
                    2'd0: part.r = i_byte;
                    2'd1: part.g = i_byte;
                    2'd2: part.b = i_byte;
                    default: part.a = i_byte;
                endcase
                o_dec.next.partial = part;
                o_dec.next.left    = i_state.left - 3'd1;
                if (o_dec.next.left == 3'd0) begin
                    o_dec.next.pend = PEND_NONE;
                    pix             = part;
                    finish          = 1'b1;
                end
            end
            PEND_LUMA: begin
                pix.r           = i_state.prev.r + vg - 8'd8 + {4'b0000, i_byte[7:4]};
                pix.g           = i_state.prev.g + vg;
                pix.b           = i_state.prev.b + vg - 8'd8 + {4'b0000, i_byte[3:0]};
                o_dec.next.pend = PEND_NONE;
                o_dec.next.left = 3'd0;
                finish          = 1'b1;
            end
            default: begin
                if (i_byte == OP_RGB || i_byte == OP_RGBA) begin
                    o_dec.next.pend    = (i_byte == OP_RGB) ? PEND_RGB : PEND_RGBA;
                    o_dec.next.left    = (i_byte == OP_RGB) ? 3'd3 : 3'd4;
                    o_dec.next.partial = i_state.prev;
                end else begin
                    unique case (i_byte[7:6])
                        TAG_DIFF: begin
                            pix.r  = i_state.prev.r + {6'd0, i_byte[5:4]} - 8'd2;
                            pix.g  = i_state.prev.g + {6'd0, i_byte[3:2]} - 8'd2;
                            pix.b  = i_state.prev.b + {6'd0, i_byte[1:0]} - 8'd2;
                            finish = 1'b1;
                        end
                        TAG_LUMA: begin
                            o_dec.next.pend      = PEND_LUMA;
                            o_dec.next.left      = 3'd1;
                            o_dec.next.luma_diff = i_byte[5:0];
                        end
                        TAG_RUN: begin
                            o_dec.emit  = 1'b1;
                            o_dec.is_run = 1'b1;
                            o_dec.wr_en = 1'b1;
                        end
                        default: begin
                            pix    = i_idx_pixel;
                            finish = 1'b1;
                        end
                    endcase
                end
            end
        endcase

        if (finish) begin
            o_dec.emit      = 1'b1;
            o_dec.wr_en     = 1'b1;
            o_dec.next.prev = pix;
        end
        o_dec.pixel   = pix;
        o_dec.wr_addr = pixel_slot(pix);
    end

endmodule

### rtl/qoi_chunk_decoder.sv
// Decodes the chunk bytes of a QOI image, one byte per transaction on the
// input channel, into RGBA pixels, one per transaction on the output channel.
// The header must be stripped before the first byte and the end marker is
// not recognized, so the source stops feeding bytes after the last chunk.
// A byte is taken when i_valid is high and o_stall is low. It sits in one
// decode register, and its pixel is loaded into the output register that
// drives o_valid once that register is empty or i_stall is low.
// Bytes are taken at one per cycle unless the output stalls: RGB, RGBA and
// LUMA operand bytes, op bytes that open them, and INDEX and DIFF ops alike.
// A RUN op holds o_stall high while it emits its 1 to 62 copies of the
// previous pixel, one per cycle unless i_stall holds them; o_end_of_burst
// marks the last copy and is high on every pixel that is not part of a run.
// The 64-entry color index is a RAM read as a byte is taken, ahead of decode;
// a write in the same cycle is forwarded, and per-entry valid bits make
// unwritten entries read as zero, so no clearing pass is needed after reset.
// Reset restores the previous pixel to opaque black, drops any partial op
// and empties both registers. When i_stall is high the output register
// holds its pixel and the block keeps taking bytes until the decode
// register is occupied by a byte whose pixel cannot yet be placed.
module qoi_chunk_decoder
    import qcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic [7:0] o_alpha,
    output logic       o_end_of_burst
);

    t_dec_state          r_st;
    logic                r_a_valid;
    logic [7:0]          r_a_byte;
    logic [5:0]          r_run_cnt;
    logic [IDX_DEPTH-1:0] r_idx_vld;
    logic                r_rd_vld;
    logic                r_fwd_hit;
    t_pixel              r_fwd_data;
    logic                r_o_valid;
    t_pixel              r_o_pix;
    logic                r_o_eob;

    t_dec_out            dec;
    t_pixel              ram_rdata;
    t_pixel              idx_pixel;
    logic                in_accept;
    logic                out_ready;
    logic                a_step;
    logic                a_last;
    logic                a_done;
    logic                ram_we;

    assign in_accept = i_valid && !o_stall;
    assign out_ready = !r_o_valid || !i_stall;
    assign a_step    = r_a_valid && (!dec.emit || out_ready);
    assign a_last    = !dec.is_run || (r_run_cnt == dec.run_arg);
    assign a_done    = a_step && a_last;
    assign o_stall   = r_a_valid && !a_done;
    assign ram_we    = a_done && dec.wr_en;

    assign idx_pixel = r_fwd_hit ? r_fwd_data : (r_rd_vld ? ram_rdata : '0);

    qcd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (IDX_DEPTH)
    ) u_index (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (dec.wr_addr),
        .i_wdata (dec.pixel),
        .i_re    (in_accept),
        .i_raddr (i_data_byte[IDX_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    qcd_op_decode u_decode (
        .i_byte      (r_a_byte),
        .i_state     (r_st),
        .i_idx_pixel (idx_pixel),
        .o_dec       (dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.pend      <= PEND_NONE;
            r_st.left      <= 3'd0;
            r_st.partial   <= '0;
            r_st.luma_diff <= 6'd0;
            r_st.prev      <= PIX_RESET;
            r_a_valid      <= 1'b0;
            r_run_cnt      <= 6'd0;
            r_idx_vld      <= '0;
            r_rd_vld       <= 1'b0;
            r_fwd_hit      <= 1'b0;
            r_o_valid      <= 1'b0;
        end else begin
            if (a_done) begin
                r_st <= dec.next;
            end
            if (ram_we) begin
                r_idx_vld[dec.wr_addr] <= 1'b1;
            end
            if (in_accept) begin
                r_a_valid <= 1'b1;
                r_run_cnt <= 6'd0;
                r_rd_vld  <= r_idx_vld[i_data_byte[IDX_AW-1:0]];
                r_fwd_hit <= ram_we && (dec.wr_addr == i_data_byte[IDX_AW-1:0]);
            end else begin
                if (a_done) begin
                    r_a_valid <= 1'b0;
                end
                if (a_step && !a_last) begin
                    r_run_cnt <= r_run_cnt + 6'd1;
                end
            end
            if (a_step && dec.emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_byte   <= i_data_byte;
            r_fwd_data <= dec.pixel;
        end
        if (a_step && dec.emit) begin
            r_o_pix <= dec.pixel;
            r_o_eob <= a_last;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_red          = r_o_pix.r;
    assign o_green        = r_o_pix.g;
    assign o_blue         = r_o_pix.b;
    assign o_alpha        = r_o_pix.a;
    assign o_end_of_burst = r_o_eob;

    a_run_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && dec.is_run && !a_last) |-> o_stall)
        else $error("input taken in the middle of a run");

    a_run_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && dec.is_run) |-> (r_run_cnt <= dec.run_arg))
        else $error("run counter passed its length");

    a_rgb_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.pend == PEND_RGB) |-> (r_st.left >= 3'd1 && r_st.left <= 3'd3))
        else $error("RGB operand count out of range");

    a_rgba_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.pend == PEND_RGBA) |-> (r_st.left >= 3'd1 && r_st.left <= 3'd4))
        else $error("RGBA operand count out of range");

    a_emit_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_step && dec.emit) |=> o_valid)
        else $error("decoded pixel did not reach the output register");

endmodule
